@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// Field widths, operation codes, stored entry and result word layouts.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W         = 32;
    localparam int PRIO_W          = 16;
    localparam int OCC_W           = 5;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic                      removed_valid;
        logic                      empty_error;
        logic                      full_error;
        logic [OCC_W-1:0]          occupancy;
    } res_t;

endpackage

@@ rtl/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_if - handshake channels of the sorted priority queue
// Command channel in, result channel out; valid/ready with payload.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [spq_pkg::VALUE_W-1:0] item_value;
    logic signed [spq_pkg::PRIO_W-1:0]  item_priority;

    modport source (output valid, output op, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input op, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [spq_pkg::VALUE_W-1:0] removed_value;
    logic                              removed_valid;
    logic                              empty_error;
    logic                              full_error;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output removed_value, output removed_valid,
                    output empty_error, output full_error, output occupancy,
                    input ready);
    modport sink   (input valid, input removed_value, input removed_valid,
                    input empty_error, input full_error, input occupancy,
                    output ready);
endinterface

@@ rtl/spq_mem.sv @@
// ----------------------------------------------------------------------------
// spq_mem - entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
    input  spq_pkg::entry_t                  wr_entry,
    input  logic                             rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
    output spq_pkg::entry_t                  rd_entry
);
    import spq_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/spq_seq.sv @@
// ----------------------------------------------------------------------------
// spq_seq - insertion / removal sequencer
// Walks the store one entry at a time through a single priority comparator,
// moving entries up on enqueue and down on dequeue.
// ----------------------------------------------------------------------------
module spq_seq #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    spq_cmd_if.sink                          cmd,
    output logic                             wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
    output spq_pkg::entry_t                  wr_entry,
    output logic                             rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
    input  spq_pkg::entry_t                  rd_entry,
    output logic                             res_valid,
    input  logic                             res_ready,
    output spq_pkg::res_t                    res
);
    import spq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = CNT_W + OCC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERD  = 4'd1;
    localparam logic [3:0] S_ECMP = 4'd2;
    localparam logic [3:0] S_EWR  = 4'd3;
    localparam logic [3:0] S_DRD0 = 4'd4;
    localparam logic [3:0] S_DCAP = 4'd5;
    localparam logic [3:0] S_DRD  = 4'd6;
    localparam logic [3:0] S_DWR  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          lim_reg, lim_next;
    entry_t                    new_reg, new_next;
    logic signed [VALUE_W-1:0] rem_val_reg, rem_val_next;
    logic                      rem_valid_reg, rem_valid_next;
    logic                      empty_reg, empty_next;
    logic                      full_reg, full_next;

    logic [CNT_W-1:0]          idx_m1;
    logic [CNT_W-1:0]          idx_p1;
    logic                      shift_up;
    logic [EXT_W-1:0]          cnt_ext;

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign shift_up = $signed(rd_entry.prio) >= $signed(new_reg.prio);
    assign cnt_ext  = EXT_W'(count_reg);

    assign cmd.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);

    always_comb
    begin
        res.removed_value = rem_val_reg;
        res.removed_valid = rem_valid_reg;
        res.empty_error   = empty_reg;
        res.full_error    = full_reg;
        res.occupancy     = cnt_ext[OCC_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        new_next       = new_reg;
        rem_val_next   = rem_val_reg;
        rem_valid_next = rem_valid_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_entry       = new_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    new_next.value = cmd.item_value;
                    new_next.prio  = cmd.item_priority;
                    rem_val_next   = '0;
                    rem_valid_next = 1'b0;
                    empty_next     = 1'b0;
                    full_next      = 1'b0;
                    if (cmd.op == OP_ENQ)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            full_next  = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            count_next = count_reg + CNT_W'(1);
                            state_next = (count_reg == '0) ? S_EWR : S_ERD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            empty_next = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            lim_next   = count_reg;
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_DRD0;
                        end
                    end
                end
            end
            S_ERD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_m1[IDX_W-1:0];
                state_next = S_ECMP;
            end
            S_ECMP:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    wr_entry   = rd_entry;
                    idx_next   = idx_m1;
                    state_next = (idx_m1 == '0) ? S_EWR : S_ERD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EWR:
            begin
                wr_en      = 1'b1;
                state_next = S_FIN;
            end
            S_DRD0:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_DCAP;
            end
            S_DCAP:
            begin
                rem_val_next   = rd_entry.value;
                rem_valid_next = 1'b1;
                idx_next       = CNT_W'(1);
                state_next     = (lim_reg > CNT_W'(1)) ? S_DRD : S_FIN;
            end
            S_DRD:
            begin
                rd_en      = 1'b1;
                state_next = S_DWR;
            end
            S_DWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_m1[IDX_W-1:0];
                wr_entry   = rd_entry;
                idx_next   = idx_p1;
                state_next = (idx_p1 < lim_reg) ? S_DRD : S_FIN;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        lim_reg       <= lim_next;
        new_reg       <= new_next;
        rem_val_reg   <= rem_val_next;
        rem_valid_reg <= rem_valid_next;
        empty_reg     <= empty_next;
        full_reg      <= full_next;
    end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded priority queue kept in sorted order
// Sequencer plus entry store, with a registered result word at the output.
// ----------------------------------------------------------------------------
// Each command word (enqueue or dequeue) is handled by one sequencer that
// steps through the entry store through a single read port and a single
// priority comparator, reading and then writing back each entry visited. An
// enqueue moves the stored entries at or above the new priority back by one
// place and writes the new entry in the gap; a dequeue takes the front entry
// and moves every remaining entry forward by one place; a dropped enqueue or
// an empty dequeue touches no entry. The command channel is not ready while a
// word is in progress. Results leave through an output register, so a
// finished word may wait there while the next command runs.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_cmd_if.sink   cmd,
    spq_res_if.source res
);
    import spq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_entry;
    logic             seq_valid;
    logic             seq_ready;
    res_t             seq_res;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg, out_next;

    spq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_entry  (rd_entry),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .res       (seq_res)
    );

    assign seq_ready = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (seq_valid && seq_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = seq_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.removed_value = out_reg.removed_value;
    assign res.removed_valid = out_reg.removed_valid;
    assign res.empty_error   = out_reg.empty_error;
    assign res.full_error    = out_reg.full_error;
    assign res.occupancy     = out_reg.occupancy;

endmodule
